// ===== hdl/bmp_palette_image_decoder_unit_defines.svh =====
// Assertion macros for the palette BMP decoder.
// Used by the modules that carry concurrent checks; expects clk and rst in scope.
`ifndef BMP_PALETTE_IMAGE_DECODER_UNIT_DEFINES_SVH
`define BMP_PALETTE_IMAGE_DECODER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BPID_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BPID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bpid_pkg.sv =====
// Shared types and constants for the palette BMP decoder.
// No dependencies; used by bpid_parse, bpid_expand and the top level.
package bpid_pkg;

  localparam int DEF_MAX_WIDTH   = 4096;
  localparam int DEF_MAX_HEIGHT  = 4096;
  localparam int DEF_PALETTE_MAX = 256;

  // Result kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PALETTE = 2'd1;
  localparam logic [1:0] KIND_PIXEL   = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  // Error codes, in order of precedence
  localparam logic [7:0] ERR_SIGNATURE = 8'd1;
  localparam logic [7:0] ERR_FORMAT    = 8'd2;
  localparam logic [7:0] ERR_DEPTH     = 8'd3;
  localparam logic [7:0] ERR_SIZE      = 8'd4;
  localparam logic [7:0] ERR_OFFSET    = 8'd5;
  localparam logic [7:0] ERR_SHORT     = 8'd6;

  // Supported bit depths
  localparam logic [3:0] DEPTH_1 = 4'd1;
  localparam logic [3:0] DEPTH_4 = 4'd4;
  localparam logic [3:0] DEPTH_8 = 4'd8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [12:0] column;
    logic [12:0] row;
    logic [7:0]  value;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        top_down;
    logic [8:0]  entry_count;
    logic        last_of_run;
  } result_t;

  // One byte's worth of results: a single result, or a run of pixels that
  // starts at column and takes count indices out of value.
  typedef struct packed {
    logic [1:0]  kind;
    logic [12:0] column;
    logic [12:0] row;
    logic [7:0]  value;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        top_down;
    logic [8:0]  entry_count;
    logic [3:0]  count;
    logic [3:0]  depth;
  } desc_t;

endpackage

// ===== hdl/bmp_palette_image_decoder_unit.sv =====
// Palette BMP decoder top level: byte parser feeding a result run stage (bpid_pkg).
// A result passes through the parser's descriptor register and the run stage's hold register.
// Throughput: one byte per cycle while each byte gives at most one result and out_stall is low; a pixel
//   byte gives up to 8, 2 or 1 results at 1, 4 or 8 bits, one per cycle from the run stage.
// Reset: synchronous rst clears parser state to header wait and empties both stages.
module bmp_palette_image_decoder_unit #(
  parameter int MAX_WIDTH   = bpid_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = bpid_pkg::DEF_MAX_HEIGHT,
  parameter int PALETTE_MAX = bpid_pkg::DEF_PALETTE_MAX
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  bpid_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bpid_pkg::result_t  out_data
);

  logic            desc_valid;
  logic            desc_take;
  bpid_pkg::desc_t desc;

  bpid_parse #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PALETTE_MAX(PALETTE_MAX)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .desc_valid(desc_valid),
    .desc_take (desc_take),
    .desc      (desc)
  );

  bpid_expand u_expand (
    .clk       (clk),
    .rst       (rst),
    .desc_valid(desc_valid),
    .desc_take (desc_take),
    .desc      (desc),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/bpid_parse.sv =====
// Byte parser: header fields, palette entries, offset skip and row walk.
// Depends on bpid_pkg and the assertion macro header; emits at most one descriptor per byte.
`include "bmp_palette_image_decoder_unit_defines.svh"

module bpid_parse #(
  parameter int MAX_WIDTH   = bpid_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = bpid_pkg::DEF_MAX_HEIGHT,
  parameter int PALETTE_MAX = bpid_pkg::DEF_PALETTE_MAX
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  bpid_pkg::in_item_t in_data,
  output logic               desc_valid,
  input  logic               desc_take,
  output bpid_pkg::desc_t    desc
);

  localparam int WW        = $clog2(MAX_WIDTH + 1);
  localparam int HW        = $clog2(MAX_HEIGHT + 1);
  localparam int EW        = $clog2(PALETTE_MAX + 1);
  localparam int MAX_PITCH = ((MAX_WIDTH * 8 + 31) / 32) * 4;
  localparam int PW        = $clog2(MAX_PITCH + 1);
  localparam int XW        = $clog2(MAX_WIDTH + 32);
  localparam int BW        = WW + 8;

  localparam logic [5:0]  POS_SIG      = 6'd1;
  localparam logic [5:0]  POS_OFFSET   = 6'd13;
  localparam logic [5:0]  POS_HDR_SIZE = 6'd17;
  localparam logic [5:0]  POS_WIDTH    = 6'd21;
  localparam logic [5:0]  POS_HEIGHT   = 6'd25;
  localparam logic [5:0]  POS_DEPTH    = 6'd29;
  localparam logic [5:0]  POS_COMPRESS = 6'd33;
  localparam logic [5:0]  POS_COLOURS  = 6'd49;
  localparam logic [5:0]  POS_LAST     = 6'd53;
  localparam logic [31:0] HDR_LEN      = 32'd54;
  localparam logic [31:0] MIN_INFO     = 32'd40;
  localparam logic [15:0] SIG_BM       = 16'h4D42;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_PALETTE,
    PH_SKIP,
    PH_PIXELS,
    PH_IGNORE
  } phase_t;

  phase_t          phase, phase_next;
  logic [31:0]     byte_position, byte_position_next;
  logic [31:0]     data_offset, data_offset_next;
  logic [31:0]     shreg, shreg_next;
  logic            unsup, unsup_next;
  logic            w_big, w_big_next;
  logic            h_big, h_big_next;
  logic            h_neg, h_neg_next;
  logic [WW-1:0]   raw_w, raw_w_next;
  logic [HW-1:0]   raw_h, raw_h_next;
  logic            raw_d_ok, raw_d_ok_next;
  logic [3:0]      raw_d, raw_d_next;
  logic [8:0]      raw_cnt, raw_cnt_next;
  logic [WW-1:0]   image_width, image_width_next;
  logic [HW-1:0]   image_height, image_height_next;
  logic [3:0]      depth_bits, depth_bits_next;
  logic            flip_flag, flip_flag_next;
  logic [EW-1:0]   palette_count, palette_count_next;
  logic [23:0]     color_bytes, color_bytes_next;
  logic [EW-1:0]   entry_counter, entry_counter_next;
  logic [HW-1:0]   row_counter, row_counter_next;
  logic [PW-1:0]   byte_in_row, byte_in_row_next;
  logic [PW-1:0]   row_pitch, row_pitch_next;
  logic [XW-1:0]   x_base, x_base_next;

  logic            accept;
  logic            eof;
  logic [7:0]      din;
  logic [31:0]     shreg_n;
  logic [31:0]     pos_inc;
  logic [31:0]     hmag;
  logic [8:0]      cnt_col;
  logic [31:0]     off_min;
  logic [7:0]      hdr_code;
  logic [BW-1:0]   row_bits;
  logic [BW-1:0]   row_bits_rnd;
  logic [PW-1:0]   pitch_calc;
  logic [1:0]      pal_k;
  logic [EW-1:0]   ec_inc;
  logic            enter_now;
  logic [3:0]      per;
  logic [XW-1:0]   width_x;
  logic [XW-1:0]   rem;
  logic [3:0]      pix_count;
  logic [HW-1:0]   dst_row;
  logic [PW:0]     bir_inc;
  logic [HW:0]     row_inc;
  bpid_pkg::desc_t nd;
  logic            nd_valid;

  assign in_stall = desc_valid && !desc_take;
  assign accept   = in_valid && !in_stall;
  assign eof      = in_data.end_of_file;
  assign din      = in_data.data_byte;

  // Header arithmetic
  assign shreg_n = {din, shreg[31:8]};
  assign pos_inc = byte_position + 32'd1;
  assign hmag    = shreg_n[31] ? (32'd0 - shreg_n) : shreg_n;
  assign cnt_col = (shreg_n == 32'd0) ? (9'd1 << raw_d)
                 : ((shreg_n > 32'd256) ? 9'd256 : shreg_n[8:0]);
  assign off_min = HDR_LEN + {21'd0, raw_cnt, 2'b00};

  always_comb begin
    if (unsup) begin
      hdr_code = bpid_pkg::ERR_FORMAT;
    end else if (!raw_d_ok) begin
      hdr_code = bpid_pkg::ERR_DEPTH;
    end else if (w_big || h_big || (raw_cnt > 9'(PALETTE_MAX))) begin
      hdr_code = bpid_pkg::ERR_SIZE;
    end else if (data_offset < off_min) begin
      hdr_code = bpid_pkg::ERR_OFFSET;
    end else begin
      hdr_code = 8'd0;
    end
  end

  // Row pitch: bits per row rounded up to whole 32-bit words, in bytes
  always_comb begin
    case (raw_d)
      bpid_pkg::DEPTH_8: row_bits = BW'(raw_w) << 3;
      bpid_pkg::DEPTH_4: row_bits = BW'(raw_w) << 2;
      default:           row_bits = BW'(raw_w);
    endcase
  end
  assign row_bits_rnd = row_bits + BW'(31);
  assign pitch_calc   = PW'({row_bits_rnd >> 5, 2'b00});

  // Palette and row walk
  assign pal_k     = byte_position[1:0] + 2'd2;
  assign ec_inc    = entry_counter + EW'(1);
  assign enter_now = pos_inc >= data_offset;

  always_comb begin
    case (depth_bits)
      bpid_pkg::DEPTH_8: per = 4'd1;
      bpid_pkg::DEPTH_4: per = 4'd2;
      default:           per = 4'd8;
    endcase
  end
  assign width_x   = XW'(image_width);
  assign rem       = width_x - x_base;
  assign pix_count = (x_base >= width_x) ? 4'd0
                   : ((rem >= XW'(per)) ? per : rem[3:0]);
  assign dst_row   = flip_flag ? row_counter : (image_height - HW'(1) - row_counter);
  assign bir_inc   = {1'b0, byte_in_row} + (PW+1)'(1);
  assign row_inc   = {1'b0, row_counter} + (HW+1)'(1);

  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    data_offset_next   = data_offset;
    shreg_next         = shreg;
    unsup_next         = unsup;
    w_big_next         = w_big;
    h_big_next         = h_big;
    h_neg_next         = h_neg;
    raw_w_next         = raw_w;
    raw_h_next         = raw_h;
    raw_d_ok_next      = raw_d_ok;
    raw_d_next         = raw_d;
    raw_cnt_next       = raw_cnt;
    image_width_next   = image_width;
    image_height_next  = image_height;
    depth_bits_next    = depth_bits;
    flip_flag_next     = flip_flag;
    palette_count_next = palette_count;
    color_bytes_next   = color_bytes;
    entry_counter_next = entry_counter;
    row_counter_next   = row_counter;
    byte_in_row_next   = byte_in_row;
    row_pitch_next     = row_pitch;
    x_base_next        = x_base;
    nd                 = '0;
    nd.count           = 4'd1;
    nd_valid           = 1'b0;

    case (phase)
      PH_HEADER: begin
        shreg_next         = shreg_n;
        byte_position_next = pos_inc;
        case (byte_position[5:0])
          POS_SIG: begin
            if (shreg_n[31:16] != SIG_BM) begin
              phase_next = PH_IGNORE;
              nd.kind    = bpid_pkg::KIND_ERROR;
              nd.value   = bpid_pkg::ERR_SIGNATURE;
              nd_valid   = 1'b1;
            end
          end
          POS_OFFSET: data_offset_next = shreg_n;
          POS_HDR_SIZE: begin
            if (shreg_n < MIN_INFO) unsup_next = 1'b1;
          end
          POS_WIDTH: begin
            w_big_next = shreg_n > 32'(MAX_WIDTH);
            raw_w_next = shreg_n[WW-1:0];
          end
          POS_HEIGHT: begin
            h_neg_next = shreg_n[31];
            h_big_next = hmag > 32'(MAX_HEIGHT);
            raw_h_next = hmag[HW-1:0];
          end
          POS_DEPTH: begin
            raw_d_ok_next = (shreg_n[31:16] == 16'(bpid_pkg::DEPTH_1)) ||
                            (shreg_n[31:16] == 16'(bpid_pkg::DEPTH_4)) ||
                            (shreg_n[31:16] == 16'(bpid_pkg::DEPTH_8));
            raw_d_next    = shreg_n[19:16];
          end
          POS_COMPRESS: begin
            if (shreg_n != 32'd0) unsup_next = 1'b1;
          end
          POS_COLOURS: raw_cnt_next = cnt_col;
          POS_LAST: begin
            nd_valid = 1'b1;
            if (hdr_code != 8'd0) begin
              phase_next = PH_IGNORE;
              nd.kind    = bpid_pkg::KIND_ERROR;
              nd.value   = hdr_code;
            end else begin
              image_width_next   = raw_w;
              image_height_next  = raw_h;
              depth_bits_next    = raw_d;
              flip_flag_next     = h_neg;
              palette_count_next = EW'(raw_cnt);
              row_pitch_next     = pitch_calc;
              entry_counter_next = '0;
              color_bytes_next   = 24'd0;
              phase_next         = PH_PALETTE;
              nd.kind            = bpid_pkg::KIND_HEADER;
              nd.column          = 13'(raw_w);
              nd.row             = 13'(raw_h);
              nd.value           = {4'd0, raw_d};
              nd.top_down        = h_neg;
              nd.entry_count     = raw_cnt;
            end
          end
          default: ;
        endcase
        // Truncated header: report only if nothing else ended it
        if (eof && (phase_next == PH_HEADER)) begin
          nd.kind  = bpid_pkg::KIND_ERROR;
          nd.value = bpid_pkg::ERR_SHORT;
          nd_valid = 1'b1;
        end
      end

      PH_PALETTE: begin
        byte_position_next = pos_inc;
        case (pal_k)
          2'd0: color_bytes_next[7:0]   = din;
          2'd1: color_bytes_next[15:8]  = din;
          2'd2: color_bytes_next[23:16] = din;
          default: begin
            nd.kind            = bpid_pkg::KIND_PALETTE;
            nd.column          = 13'(entry_counter);
            nd.red             = color_bytes[23:16];
            nd.green           = color_bytes[15:8];
            nd.blue            = color_bytes[7:0];
            nd_valid           = 1'b1;
            color_bytes_next   = 24'd0;
            entry_counter_next = ec_inc;
            if (ec_inc >= palette_count) begin
              phase_next = PH_SKIP;
              if (enter_now) begin
                row_counter_next = '0;
                byte_in_row_next = '0;
                x_base_next      = '0;
                phase_next       = ((image_width == '0) || (image_height == '0))
                                 ? PH_IGNORE : PH_PIXELS;
              end
            end
          end
        endcase
      end

      PH_SKIP: begin
        byte_position_next = pos_inc;
        if (enter_now) begin
          row_counter_next = '0;
          byte_in_row_next = '0;
          x_base_next      = '0;
          phase_next       = ((image_width == '0) || (image_height == '0))
                           ? PH_IGNORE : PH_PIXELS;
        end
      end

      PH_PIXELS: begin
        if (pix_count != 4'd0) begin
          nd.kind   = bpid_pkg::KIND_PIXEL;
          nd.column = 13'(x_base);
          nd.row    = 13'(dst_row);
          nd.value  = din;
          nd.count  = pix_count;
          nd.depth  = depth_bits;
          nd_valid  = 1'b1;
        end
        // Advance within the row, or wrap to the next one at the padded pitch
        if (bir_inc >= {1'b0, row_pitch}) begin
          byte_in_row_next = '0;
          x_base_next      = '0;
          row_counter_next = row_inc[HW-1:0];
          if (row_inc >= {1'b0, image_height}) phase_next = PH_IGNORE;
        end else begin
          byte_in_row_next = bir_inc[PW-1:0];
          x_base_next      = x_base + XW'(per);
        end
      end

      default: ;
    endcase

    // Final byte of the file: rewind everything to header wait
    if (eof) begin
      phase_next         = PH_HEADER;
      byte_position_next = 32'd0;
      data_offset_next   = 32'd0;
      shreg_next         = 32'd0;
      unsup_next         = 1'b0;
      w_big_next         = 1'b0;
      h_big_next         = 1'b0;
      h_neg_next         = 1'b0;
      raw_w_next         = '0;
      raw_h_next         = '0;
      raw_d_ok_next      = 1'b0;
      raw_d_next         = 4'd0;
      raw_cnt_next       = 9'd0;
      image_width_next   = '0;
      image_height_next  = '0;
      depth_bits_next    = 4'd0;
      flip_flag_next     = 1'b0;
      palette_count_next = '0;
      color_bytes_next   = 24'd0;
      entry_counter_next = '0;
      row_counter_next   = '0;
      byte_in_row_next   = '0;
      row_pitch_next     = '0;
      x_base_next        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      byte_position <= 32'd0;
      data_offset   <= 32'd0;
      shreg         <= 32'd0;
      unsup         <= 1'b0;
      w_big         <= 1'b0;
      h_big         <= 1'b0;
      h_neg         <= 1'b0;
      raw_w         <= '0;
      raw_h         <= '0;
      raw_d_ok      <= 1'b0;
      raw_d         <= 4'd0;
      raw_cnt       <= 9'd0;
      image_width   <= '0;
      image_height  <= '0;
      depth_bits    <= 4'd0;
      flip_flag     <= 1'b0;
      palette_count <= '0;
      color_bytes   <= 24'd0;
      entry_counter <= '0;
      row_counter   <= '0;
      byte_in_row   <= '0;
      row_pitch     <= '0;
      x_base        <= '0;
      desc_valid    <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        byte_position <= byte_position_next;
        data_offset   <= data_offset_next;
        shreg         <= shreg_next;
        unsup         <= unsup_next;
        w_big         <= w_big_next;
        h_big         <= h_big_next;
        h_neg         <= h_neg_next;
        raw_w         <= raw_w_next;
        raw_h         <= raw_h_next;
        raw_d_ok      <= raw_d_ok_next;
        raw_d         <= raw_d_next;
        raw_cnt       <= raw_cnt_next;
        image_width   <= image_width_next;
        image_height  <= image_height_next;
        depth_bits    <= depth_bits_next;
        flip_flag     <= flip_flag_next;
        palette_count <= palette_count_next;
        color_bytes   <= color_bytes_next;
        entry_counter <= entry_counter_next;
        row_counter   <= row_counter_next;
        byte_in_row   <= byte_in_row_next;
        row_pitch     <= row_pitch_next;
        x_base        <= x_base_next;
        desc_valid    <= nd_valid;
      end else if (desc_take) begin
        desc_valid <= 1'b0;
      end
    end
  end

  // Descriptor payload: load with each transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      desc <= nd;
    end
  end

  `BPID_ASSERT_NOW(a_pixel_depth, phase == PH_PIXELS, (depth_bits == bpid_pkg::DEPTH_1) || (depth_bits == bpid_pkg::DEPTH_4) || (depth_bits == bpid_pkg::DEPTH_8), "pixel phase with unsupported depth")
  `BPID_ASSERT_NEXT(a_eof_rewind, accept && eof, (phase == PH_HEADER) && (byte_position == 32'd0), "end of file did not rewind the parser")

endmodule

// ===== hdl/bpid_expand.sv =====
// Result stage: holds one descriptor and issues its results one per cycle while out_stall is low.
// Depends on bpid_pkg and the assertion macro header.
`include "bmp_palette_image_decoder_unit_defines.svh"

module bpid_expand (
  input  logic              clk,
  input  logic              rst,
  input  logic              desc_valid,
  output logic              desc_take,
  input  bpid_pkg::desc_t   desc,
  output logic              out_valid,
  input  logic              out_stall,
  output bpid_pkg::result_t out_data
);

  bpid_pkg::desc_t act;
  logic            act_valid;
  logic [2:0]      idx;
  logic [3:0]      idx_ext;
  logic            last;
  logic            out_take;
  logic [7:0]      pix_value;

  assign idx_ext   = {1'b0, idx};
  assign last      = (idx_ext + 4'd1) == act.count;
  assign out_valid = act_valid;
  assign out_take  = act_valid && !out_stall;
  assign desc_take = desc_valid && (!act_valid || (out_take && last));

  always_comb begin
    case (act.depth)
      bpid_pkg::DEPTH_8: pix_value = act.value;
      bpid_pkg::DEPTH_4: pix_value = (idx == 3'd0) ? {4'd0, act.value[7:4]}
                                                   : {4'd0, act.value[3:0]};
      default:           pix_value = {7'd0, act.value[3'd7 - idx]};
    endcase
  end

  always_comb begin
    out_data.kind        = act.kind;
    out_data.column      = act.column;
    out_data.row         = act.row;
    out_data.value       = act.value;
    out_data.red         = act.red;
    out_data.green       = act.green;
    out_data.blue        = act.blue;
    out_data.top_down    = act.top_down;
    out_data.entry_count = act.entry_count;
    out_data.last_of_run = last;
    if (act.kind == bpid_pkg::KIND_PIXEL) begin
      out_data.column = act.column + 13'(idx);
      out_data.value  = pix_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act_valid <= 1'b0;
      idx       <= 3'd0;
    end else if (desc_take) begin
      act_valid <= 1'b1;
      idx       <= 3'd0;
    end else if (out_take) begin
      if (last) begin
        act_valid <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  // Hold the payload until the next descriptor is taken
  always_ff @(posedge clk) begin
    if (desc_take) begin
      act <= desc;
    end
  end

  `BPID_ASSERT_NOW(a_run_index, act_valid, (act.count != 4'd0) && (idx_ext < act.count), "run index outside its descriptor")
  `BPID_ASSERT_NEXT(a_load_start, desc_take, act_valid && (idx == 3'd0), "descriptor load did not start a run")
  `BPID_ASSERT_NEXT(a_run_continues, out_take && !last, act_valid, "run dropped before its last result")

endmodule
